// File: src/combined_waveform_pulldown_assert.svh
// Assertion macros used by the pulldown predictor top level.
`ifndef COMBINED_WAVEFORM_PULLDOWN_ASSERT_SVH
`define COMBINED_WAVEFORM_PULLDOWN_ASSERT_SVH

// Checked property, muted while reset is high.
`define CWP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked property that also holds across reset.
`define CWP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: src/cwp_pkg.sv
// Shared types and constants of the combined-waveform pulldown predictor.
package cwp_pkg;

   localparam int WEIGHT_W = 24;
   localparam int CFG_W    = 24;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_TOP_GAIN  = 2'd0,
      REG_PULSE     = 2'd1,
      REG_THRESHOLD = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic live;
      logic top_set;
   } lane_ctrl_type;

endpackage

// File: src/cwp_lane.sv
// One output bit's multiply and compare stages of the pulldown predictor.
module cwp_lane
   import cwp_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int SUM_W     = 28
) (
   input  logic                clock,
   input  logic                adv,
   input  lane_ctrl_type       ctrl,
   input  logic [SUM_W-1:0]    n_sum,
   input  logic [SUM_W-1:0]    c_sum,
   input  logic [WEIGHT_W-1:0] w_top,
   input  logic [CFG_W-1:0]    gain,
   input  logic [CFG_W-1:0]    pulse,
   input  logic [CFG_W-1:0]    thresh,
   output logic                bit_out
);

   localparam int FW = CFG_W + 2;
   localparam int MW = FW + SUM_W + 1;
   localparam int PW = FW + SUM_W + FRAC_BITS + 2;
   localparam logic signed [FW-1:0] ONE = FW'(64'd1 << FRAC_BITS);

   logic signed [FW-1:0] fac_top;
   logic signed [FW-1:0] fac_th;
   logic signed [MW-1:0] top_term_in, top_term_ff;
   logic signed [MW-1:0] limit_in, limit_ff;
   logic [SUM_W-1:0]     c_ff;
   logic                 live_ff;
   logic signed [PW-1:0] s_val;
   logic                 bit_in, bit_ff;

   // A set top neighbor pulls with (1 - gain); a clear one with full weight.
   always_comb begin
      fac_top = ctrl.top_set ? (ONE - $signed({2'b00, gain})) : ONE;
      fac_th  = ONE - $signed({2'b00, thresh});
      top_term_in = MW'(fac_top) * MW'($signed({1'b0, w_top}));
      limit_in    = MW'(fac_th) * MW'($signed({1'b0, n_sum}));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         top_term_ff <= top_term_in;
         limit_ff    <= limit_in;
         c_ff        <= c_sum;
         live_ff     <= ctrl.live;
      end
   end

   always_comb begin
      s_val = (PW'($signed({1'b0, c_ff})) <<< FRAC_BITS) + PW'(top_term_ff)
            - (PW'($signed({1'b0, pulse})) <<< FRAC_BITS);
      bit_in = live_ff && (s_val < PW'(limit_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;

endmodule

// File: src/combined_waveform_pulldown.sv
// Top level of the combined-waveform pulldown predictor.
//
//   channel   direction  handshake               contents
//   req_      in         req_tvalid/req_tready   load or evaluate word
//   rsp_      out        rsp_tvalid/rsp_tready   predicted waveform value
//   csr_      in         APB write/read          gain, pulse, threshold
//
// A word enters every cycle that req_tready is high; an evaluate word raises
// rsp_tvalid once it has passed through every pipeline register, a load word gives none.
// The pipeline is input register, group sums, totals, multiply, compare.
// Loads write the weight table as they leave the input register, in order
// with evaluates, which read it at the same place.
// When the result register is full and not taken the whole pipeline holds.
// Reset clears all valid bits and sets the configuration registers to their defaults; the table is undefined.
module combined_waveform_pulldown
   import cwp_pkg::*;
#(
   parameter int ACC_BITS  = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // weight_index, weight_value, acc_value from bit 0 up, zero padded
   input  logic [((($clog2(2*ACC_BITS+1)) + WEIGHT_W + ACC_BITS + 7) / 8) * 8 - 1:0]
                req_tdata,
   // cmd
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // wave_value, zero padded
   output logic [((ACC_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   `include "combined_waveform_pulldown_assert.svh"

   localparam int DEPTH = 2 * ACC_BITS + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int TOP   = ACC_BITS - 1;
   localparam int GRPS  = (ACC_BITS + 3) / 4;
   localparam int GW    = WEIGHT_W + 2;
   localparam int SUM_W = WEIGHT_W + $clog2(ACC_BITS);
   localparam int OD_W  = ((ACC_BITS + 7) / 8) * 8;

   // Configuration registers.
   logic [CFG_W-1:0] gain_ff, pulse_ff, thresh_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= CFG_W'(65536);
         pulse_ff  <= '0;
         thresh_ff <= CFG_W'(58982);
      end else if (csr_wr) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_TOP_GAIN:  gain_ff   <= csr_pwdata[CFG_W-1:0];
            REG_PULSE:     pulse_ff  <= csr_pwdata[CFG_W-1:0];
            REG_THRESHOLD: thresh_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_TOP_GAIN:  csr_prdata = CSR_DW'(gain_ff);
         REG_PULSE:     csr_prdata = CSR_DW'(pulse_ff);
         REG_THRESHOLD: csr_prdata = CSR_DW'(thresh_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Every stage moves together; a full, untaken result register holds all.
   logic rsp_valid_ff;
   logic adv;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Input register.
   logic                v1_ff;
   logic                st1_cmd_ff;
   logic [IDX_W-1:0]    st1_idx_ff;
   logic [WEIGHT_W-1:0] st1_wv_ff;
   logic [ACC_BITS-1:0] st1_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st1_cmd_ff <= req_tuser[0];
         st1_idx_ff <= req_tdata[IDX_W-1:0];
         st1_wv_ff  <= req_tdata[IDX_W +: WEIGHT_W];
         st1_acc_ff <= req_tdata[IDX_W + WEIGHT_W +: ACC_BITS];
      end
   end

   // Weight table, indexed by target bit minus source bit plus ACC_BITS.
   logic [WEIGHT_W-1:0] weight_ff [DEPTH];
   logic                load_go;
   assign load_go = adv && v1_ff && (cmd_type'(st1_cmd_ff) == CMD_LOAD)
                 && (32'(st1_idx_ff) < DEPTH);

   always_ff @(posedge clock) begin
      if (load_go) begin
         weight_ff[st1_idx_ff] <= st1_wv_ff;
      end
   end

   // Stage A: per target bit, sums over groups of four neighbors.
   logic [GW-1:0]       grpn_in [ACC_BITS][GRPS];
   logic [GW-1:0]       grpc_in [ACC_BITS][GRPS];
   logic [GW-1:0]       grpn_ff [ACC_BITS][GRPS];
   logic [GW-1:0]       grpc_ff [ACC_BITS][GRPS];
   logic [WEIGHT_W-1:0] wtopA_ff [ACC_BITS];
   lane_ctrl_type       ctrlA_in [ACC_BITS];
   lane_ctrl_type       ctrlA_ff [ACC_BITS];
   logic                vA_ff;

   always_comb begin
      for (int sb = 0; sb < ACC_BITS; sb++) begin
         for (int g = 0; g < GRPS; g++) begin
            grpn_in[sb][g] = '0;
            grpc_in[sb][g] = '0;
            for (int k = 0; k < 4; k++) begin
               if ((4 * g + k < ACC_BITS) && (4 * g + k != sb)) begin
                  grpn_in[sb][g] = grpn_in[sb][g]
                                 + GW'(weight_ff[sb - (4 * g + k) + ACC_BITS]);
                  if ((4 * g + k != TOP) && !st1_acc_ff[4 * g + k]) begin
                     grpc_in[sb][g] = grpc_in[sb][g]
                                    + GW'(weight_ff[sb - (4 * g + k) + ACC_BITS]);
                  end
               end
            end
         end
         ctrlA_in[sb].top_set = st1_acc_ff[TOP];
         ctrlA_in[sb].live    = st1_acc_ff[sb] && ((sb != TOP) || (gain_ff != '0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vA_ff <= 1'b0;
      end else if (adv) begin
         vA_ff <= v1_ff && (cmd_type'(st1_cmd_ff) == CMD_EVAL);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         grpn_ff  <= grpn_in;
         grpc_ff  <= grpc_in;
         ctrlA_ff <= ctrlA_in;
         for (int sb = 0; sb < ACC_BITS; sb++) begin
            wtopA_ff[sb] <= (sb == TOP) ? '0 : weight_ff[sb + 1];
         end
      end
   end

   // Stage B: totals per target bit.
   logic [SUM_W-1:0]    nsum_in [ACC_BITS];
   logic [SUM_W-1:0]    csum_in [ACC_BITS];
   logic [SUM_W-1:0]    nsum_ff [ACC_BITS];
   logic [SUM_W-1:0]    csum_ff [ACC_BITS];
   logic [WEIGHT_W-1:0] wtopB_ff [ACC_BITS];
   lane_ctrl_type       ctrlB_ff [ACC_BITS];
   logic                vB_ff;

   always_comb begin
      for (int sb = 0; sb < ACC_BITS; sb++) begin
         nsum_in[sb] = '0;
         csum_in[sb] = '0;
         for (int g = 0; g < GRPS; g++) begin
            nsum_in[sb] = nsum_in[sb] + SUM_W'(grpn_ff[sb][g]);
            csum_in[sb] = csum_in[sb] + SUM_W'(grpc_ff[sb][g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vB_ff <= 1'b0;
      end else if (adv) begin
         vB_ff <= vA_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nsum_ff  <= nsum_in;
         csum_ff  <= csum_in;
         wtopB_ff <= wtopA_ff;
         ctrlB_ff <= ctrlA_ff;
      end
   end

   // Multiply and compare stages, one lane per output bit.
   logic                v3_ff;
   logic [ACC_BITS-1:0] wave_bits;

   for (genvar sb = 0; sb < ACC_BITS; sb++) begin : g_lane
      cwp_lane #(
         .FRAC_BITS (FRAC_BITS),
         .SUM_W     (SUM_W)
      ) u_lane (
         .clock   (clock),
         .adv     (adv),
         .ctrl    (ctrlB_ff[sb]),
         .n_sum   (nsum_ff[sb]),
         .c_sum   (csum_ff[sb]),
         .w_top   (wtopB_ff[sb]),
         .gain    (gain_ff),
         .pulse   (pulse_ff),
         .thresh  (thresh_ff),
         .bit_out (wave_bits[sb])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v3_ff        <= vB_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OD_W'(wave_bits);

   // The input side only waits behind an untaken result.
   `CWP_ASSERT(a_ready_only_stalled, !req_tready |-> (rsp_valid_ff && !rsp_tready),
      "input stalled without a waiting result")
   // A load word never turns into a result.
   `CWP_ASSERT(a_load_no_result,
      (adv && v1_ff && (cmd_type'(st1_cmd_ff) == CMD_LOAD)) |=> !vA_ff,
      "load word entered the evaluate pipeline")
   // Reset empties the result register.
   `CWP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff,
      "result valid right after reset")

endmodule
